// File: rtl/core/kpc_pkg.sv
`default_nettype none

package kpc_pkg;

  // Run counter width default
  localparam int COUNT_BITS_DEF = 8;

  // Configuration register file
  localparam int CFG_W  = 8;
  localparam int APB_DW = 32;
  localparam int CFG_AW = 4;

  localparam logic [CFG_W-1:0] PRESS_DEB_RST   = 8'd2;
  localparam logic [CFG_W-1:0] RELEASE_DEB_RST = 8'd2;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST  = 8'd100;
  localparam logic [CFG_W-1:0] REPEAT_RST      = 8'd20;

  typedef enum logic [1:0] {
    REG_PRESS_DEB   = 2'd0,
    REG_RELEASE_DEB = 2'd1,
    REG_LONG_PRESS  = 2'd2,
    REG_REPEAT      = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_WAIT    = 3'd0,
    PH_SHORT   = 3'd1,
    PH_LONG    = 3'd2,
    PH_REPEAT  = 3'd3,
    PH_RELEASE = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    KS_RELEASED    = 3'd0,
    KS_SHORT       = 3'd1,
    KS_LONG_WAIT   = 3'd2,
    KS_LONG        = 3'd3,
    KS_REPEAT_WAIT = 3'd4,
    KS_REPEAT      = 3'd5
  } key_state_e;

  typedef struct packed {
    logic [CFG_W-1:0] press_debounce_count;
    logic [CFG_W-1:0] release_debounce_count;
    logic [CFG_W-1:0] long_press_count;
    logic [CFG_W-1:0] repeat_press_count;
  } kpc_cfg_t;

  typedef struct packed {
    key_state_e prev;
    key_state_e cur;
  } key_pair_t;

endpackage

`default_nettype wire

// File: rtl/core/kpc_key_if.sv
`default_nettype none

interface kpc_key_if;
  logic valid;
  logic ready;
  logic key_down;

  modport source (output valid, output key_down, input ready);
  modport sink (input valid, input key_down, output ready);
endinterface

`default_nettype wire

// File: rtl/core/kpc_state_if.sv
`default_nettype none

interface kpc_state_if;
  logic       valid;
  logic       ready;
  logic [2:0] previous_key_state;
  logic [2:0] current_key_state;

  modport source (output valid, output previous_key_state, output current_key_state,
                  input ready);
  modport sink (input valid, input previous_key_state, input current_key_state,
                output ready);
endinterface

`default_nettype wire

// File: rtl/core/kpc_cfg_regs.sv
`default_nettype none

module kpc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [kpc_pkg::CFG_AW-1:0]     paddr,
  input  logic [kpc_pkg::APB_DW-1:0]     pwdata,
  output logic [kpc_pkg::APB_DW-1:0]     prdata,
  output logic                           pready,
  output kpc_pkg::kpc_cfg_t              cfg_o
);
  import kpc_pkg::*;

  kpc_cfg_t cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  // word address, byte lanes ignored
  assign idx   = reg_idx_e'(paddr[CFG_AW-1:2]);
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_debounce_count   <= PRESS_DEB_RST;
      cfg_q.release_debounce_count <= RELEASE_DEB_RST;
      cfg_q.long_press_count       <= LONG_PRESS_RST;
      cfg_q.repeat_press_count     <= REPEAT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_PRESS_DEB:   cfg_q.press_debounce_count   <= pwdata[CFG_W-1:0];
        REG_RELEASE_DEB: cfg_q.release_debounce_count <= pwdata[CFG_W-1:0];
        REG_LONG_PRESS:  cfg_q.long_press_count       <= pwdata[CFG_W-1:0];
        REG_REPEAT:      cfg_q.repeat_press_count     <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_PRESS_DEB:   prdata = APB_DW'(cfg_q.press_debounce_count);
      REG_RELEASE_DEB: prdata = APB_DW'(cfg_q.release_debounce_count);
      REG_LONG_PRESS:  prdata = APB_DW'(cfg_q.long_press_count);
      REG_REPEAT:      prdata = APB_DW'(cfg_q.repeat_press_count);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/core/kpc_fsm.sv
`default_nettype none

module kpc_fsm #(
  parameter int CountBits = kpc_pkg::COUNT_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               key_down_i,
  input  kpc_pkg::kpc_cfg_t  cfg_i,
  output kpc_pkg::key_pair_t report_o
);
  import kpc_pkg::*;

  // compare wide enough for both the counter and an 8-bit threshold
  localparam int CmpW = (CountBits > CFG_W) ? CountBits : CFG_W;

  phase_e               phase_q, phase_d;
  logic [CountBits-1:0] level_q, level_d, hold_q, hold_d;
  logic [CountBits-1:0] level_inc, hold_inc;
  key_pair_t            report_q, report_d;
  logic [CFG_W-1:0]     hold_limit;
  logic                 press_hit, release_hit, hold_hit;

  // saturating increments
  assign level_inc = (&level_q) ? level_q : level_q + 1'b1;
  assign hold_inc  = (&hold_q) ? hold_q : hold_q + 1'b1;

  assign hold_limit = (phase_q == PH_SHORT) ? cfg_i.long_press_count
                                            : cfg_i.repeat_press_count;

  assign press_hit   = CmpW'(level_inc) >= CmpW'(cfg_i.press_debounce_count);
  assign release_hit = CmpW'(level_inc) >= CmpW'(cfg_i.release_debounce_count);
  assign hold_hit    = CmpW'(hold_inc) >= CmpW'(hold_limit);

  // next state: phase and run counters
  always_comb begin
    phase_d = phase_q;
    level_d = level_q;
    hold_d  = hold_q;
    unique case (phase_q) inside
      PH_WAIT: begin
        hold_d = '0;
        if (key_down_i) begin
          if (press_hit) begin
            level_d = '0;
            phase_d = PH_SHORT;
          end else begin
            level_d = level_inc;
          end
        end else begin
          level_d = '0;
        end
      end
      PH_SHORT, PH_LONG, PH_REPEAT: begin
        if (!key_down_i) begin
          hold_d = '0;
          if (release_hit) begin
            level_d = '0;
            phase_d = PH_RELEASE;
          end else begin
            level_d = level_inc;
          end
        end else begin
          level_d = '0;
          if (hold_hit) begin
            hold_d  = '0;
            phase_d = (phase_q == PH_SHORT) ? PH_LONG : PH_REPEAT;
          end else begin
            hold_d = hold_inc;
          end
        end
      end
      default: begin
        level_d = '0;
        hold_d  = '0;
        phase_d = PH_WAIT;
      end
    endcase
  end

  // reported state pair
  always_comb begin
    report_d = report_q;
    unique case (phase_q)
      PH_WAIT: begin
        if (key_down_i && press_hit) begin
          report_d = '{prev: KS_RELEASED, cur: KS_SHORT};
        end
      end
      PH_SHORT: begin
        if (!key_down_i && release_hit) begin
          report_d = '{prev: KS_SHORT, cur: KS_RELEASED};
        end else if (key_down_i && hold_hit) begin
          report_d = '{prev: KS_LONG_WAIT, cur: KS_LONG};
        end else begin
          report_d = '{prev: KS_SHORT, cur: KS_LONG_WAIT};
        end
      end
      PH_LONG: begin
        if (!key_down_i && release_hit) begin
          report_d = '{prev: KS_LONG, cur: KS_RELEASED};
        end else if (key_down_i && hold_hit) begin
          report_d = '{prev: KS_REPEAT_WAIT, cur: KS_REPEAT};
        end else begin
          report_d = '{prev: KS_LONG, cur: KS_REPEAT_WAIT};
        end
      end
      PH_REPEAT: begin
        if (!key_down_i && release_hit) begin
          report_d = '{prev: KS_REPEAT_WAIT, cur: KS_RELEASED};
        end else if (key_down_i && hold_hit) begin
          report_d = '{prev: KS_REPEAT_WAIT, cur: KS_REPEAT};
        end else begin
          report_d = '{prev: KS_REPEAT, cur: KS_REPEAT_WAIT};
        end
      end
      default: begin
        report_d = '{prev: KS_RELEASED, cur: KS_RELEASED};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_WAIT;
      level_q  <= '0;
      hold_q   <= '0;
      report_q <= '{prev: KS_RELEASED, cur: KS_RELEASED};
    end else if (step_i) begin
      phase_q  <= phase_d;
      level_q  <= level_d;
      hold_q   <= hold_d;
      report_q <= report_d;
    end
  end

  assign report_o = report_q;

`ifndef NO_ASSERTIONS
  // hold run is always clear while waiting for a press
  a_wait_hold_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_WAIT) |-> (hold_q == '0))
    else $error("hold run not clear in wait phase");

  // release phase is entered with both runs cleared
  a_release_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_RELEASE) |-> (level_q == '0 && hold_q == '0))
    else $error("run counters not clear in release phase");

  // release lasts one step and reports released/released
  a_release_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && phase_q == PH_RELEASE) |=>
      (phase_q == PH_WAIT && report_q.prev == KS_RELEASED && report_q.cur == KS_RELEASED))
    else $error("release phase did not return to wait");

  // from a pressed phase, current state goes to released exactly on release
  a_pressed_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (phase_q == PH_SHORT || phase_q == PH_LONG || phase_q == PH_REPEAT)) |=>
      ((report_q.cur == KS_RELEASED) == (phase_q == PH_RELEASE)))
    else $error("released report does not match release phase");

  // nothing moves without a step
  a_no_step_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> ($stable(phase_q) && $stable(report_q) && $stable(level_q)))
    else $error("state changed without a step");
`endif

endmodule

`default_nettype wire

// File: rtl/core/key_press_classifier.sv
// Key press classifier: one sampled key level per request on key_i, one
// request per scan tick, and for every accepted sample exactly one result on
// state_o carrying the previous and current key state codes (0 released,
// 1 short, 2 long wait, 3 long, 4 repeat wait, 5 repeat). A press is confirmed
// after press_debounce_count consecutive down samples, a long press after
// long_press_count further held samples, then a repeat every
// repeat_press_count held samples; release_debounce_count consecutive up
// samples give a one-sample release phase and the block goes back to waiting.
// The block takes one sample per clock cycle while state_o is not stalled. A
// sample is first captured in an input register and is classified when it
// moves on from there (held back while the result is stalled), when the phase
// and run counters are updated and the result register loads. The rate is set
// by the update of the phase/counter state, which each sample reads and
// writes. The four thresholds sit at byte addresses 0, 4, 8 and 12 of the APB
// port and must only be written while no samples are in flight.
`default_nettype none

module key_press_classifier #(
  parameter int CountBits = kpc_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  kpc_key_if.sink                    key_i,
  kpc_state_if.source                state_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kpc_pkg::CFG_AW-1:0] paddr,
  input  logic [kpc_pkg::APB_DW-1:0] pwdata,
  output logic [kpc_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import kpc_pkg::*;

  kpc_cfg_t  cfg;
  key_pair_t report;

  // input stage
  logic in_valid_q, in_valid_d;
  logic key_q;
  // result stage valid; payload is the classifier's state pair register
  logic out_valid_q, out_valid_d;

  logic accept;
  logic advance;

  // a captured sample moves on whenever the result slot is free or draining
  assign advance     = in_valid_q && (!out_valid_q || state_o.ready);
  assign key_i.ready = !in_valid_q || advance;
  assign accept      = key_i.valid && key_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (state_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // sample payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= key_i.key_down;
    end
  end

  kpc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // the state pair only changes on a step, so it holds while the result stalls
  kpc_fsm #(
    .CountBits (CountBits)
  ) u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .key_down_i (key_q),
    .cfg_i      (cfg),
    .report_o   (report)
  );

  assign state_o.valid              = out_valid_q;
  assign state_o.previous_key_state = report.prev;
  assign state_o.current_key_state  = report.cur;

endmodule

`default_nettype wire

// File: tb/kpc_state_checker.sv
module kpc_state_checker
  import kpc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  kpc_key_if                  key_mon,
  kpc_state_if                state_mon,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  input  logic                pready,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CNT_W = COUNT_BITS_DEF;

  // predicted block state
  kpc_cfg_t         thr_q;
  phase_e           phase_q;
  logic [CNT_W-1:0] level_run;
  logic [CNT_W-1:0] hold_run;
  key_pair_t        pair_q;

  key_pair_t expected_pairs[$];
  int        mismatches;
  int        in_flight;

  assign fail_count_o = mismatches;
  assign pending_o    = in_flight;

  function automatic logic [CNT_W-1:0] bump_run(input logic [CNT_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // Advances the predicted state by one key sample and returns the pair held after it.
  function automatic key_pair_t classify_sample(input logic down);
    logic [CFG_W-1:0] hold_limit;
    phase_e           next_ph;
    key_state_e       rel_prev;
    key_state_e       fire_prev;
    key_state_e       fire_cur;
    case (phase_q)
      PH_WAIT: begin
        hold_run = '0;
        if (down) begin
          level_run = bump_run(level_run);
          if (level_run >= thr_q.press_debounce_count) begin
            level_run = '0;
            phase_q   = PH_SHORT;
            pair_q    = '{prev: KS_RELEASED, cur: KS_SHORT};
          end
        end else begin
          level_run = '0;
        end
      end
      PH_SHORT, PH_LONG, PH_REPEAT: begin
        case (phase_q)
          PH_SHORT: begin
            pair_q     = '{prev: KS_SHORT, cur: KS_LONG_WAIT};
            hold_limit = thr_q.long_press_count;
            next_ph    = PH_LONG;
            rel_prev   = KS_SHORT;
            fire_prev  = KS_LONG_WAIT;
            fire_cur   = KS_LONG;
          end
          PH_LONG: begin
            pair_q     = '{prev: KS_LONG, cur: KS_REPEAT_WAIT};
            hold_limit = thr_q.repeat_press_count;
            next_ph    = PH_REPEAT;
            rel_prev   = KS_LONG;
            fire_prev  = KS_REPEAT_WAIT;
            fire_cur   = KS_REPEAT;
          end
          default: begin
            pair_q     = '{prev: KS_REPEAT, cur: KS_REPEAT_WAIT};
            hold_limit = thr_q.repeat_press_count;
            next_ph    = PH_REPEAT;
            rel_prev   = KS_REPEAT_WAIT;
            fire_prev  = KS_REPEAT_WAIT;
            fire_cur   = KS_REPEAT;
          end
        endcase
        if (!down) begin
          hold_run  = '0;
          level_run = bump_run(level_run);
          if (level_run >= thr_q.release_debounce_count) begin
            level_run = '0;
            phase_q   = PH_RELEASE;
            pair_q    = '{prev: rel_prev, cur: KS_RELEASED};
          end
        end else begin
          level_run = '0;
          hold_run  = bump_run(hold_run);
          if (hold_run >= hold_limit) begin
            hold_run = '0;
            phase_q  = next_ph;
            pair_q   = '{prev: fire_prev, cur: fire_cur};
          end
        end
      end
      default: begin
        level_run = '0;
        hold_run  = '0;
        phase_q   = PH_WAIT;
        pair_q    = '{prev: KS_RELEASED, cur: KS_RELEASED};
      end
    endcase
    return pair_q;
  endfunction

  task automatic note_failure(input string what, input key_pair_t want, input key_pair_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected prev=%0d cur=%0d, got prev=%0d cur=%0d", $realtime, what,
               want.prev, want.cur, got.prev, got.cur);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    key_pair_t got;
    key_pair_t want;
    if (!rst_ni) begin
      thr_q     <= '{PRESS_DEB_RST, RELEASE_DEB_RST, LONG_PRESS_RST, REPEAT_RST};
      phase_q   = PH_WAIT;
      level_run = '0;
      hold_run  = '0;
      pair_q    = '{prev: KS_RELEASED, cur: KS_RELEASED};
      expected_pairs.delete();
      in_flight  <= 0;
      mismatches <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[CFG_AW-1:2]))
          REG_PRESS_DEB:   thr_q.press_debounce_count   <= pwdata[CFG_W-1:0];
          REG_RELEASE_DEB: thr_q.release_debounce_count <= pwdata[CFG_W-1:0];
          REG_LONG_PRESS:  thr_q.long_press_count       <= pwdata[CFG_W-1:0];
          REG_REPEAT:      thr_q.repeat_press_count     <= pwdata[CFG_W-1:0];
          default: ;
        endcase
      end
      if (key_mon.valid && key_mon.ready)
        expected_pairs.push_back(classify_sample(key_mon.key_down));
      if (state_mon.valid && state_mon.ready) begin
        got = '{prev: key_state_e'(state_mon.previous_key_state),
                cur: key_state_e'(state_mon.current_key_state)};
        if (expected_pairs.size() == 0) begin
          note_failure("unexpected result", '{prev: KS_RELEASED, cur: KS_RELEASED}, got);
        end else begin
          want = expected_pairs.pop_front();
          if (state_mon.previous_key_state !== want.prev ||
              state_mon.current_key_state !== want.cur)
            note_failure("state pair mismatch", want, got);
        end
      end
      in_flight <= expected_pairs.size();
    end
  end

endmodule

// File: tb/key_press_classifier_tb.sv
module key_press_classifier_tb;
  import kpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n;

  // APB-style configuration port
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  kpc_key_if   key_if ();
  kpc_state_if st_if ();

  int fail_count;
  int pending;

  // Knobs that shape the key sequences; they follow the thresholds last written.
  int pd_thr;
  int rd_thr;
  int lp_thr;
  int rp_thr;

  // Gaps on the request side and stalls on the result side are enabled per phase.
  bit allow_idle;
  int stall_left;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  key_press_classifier u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .key_i   (key_if),
    .state_o (st_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  kpc_state_checker u_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .key_mon      (key_if),
    .state_mon    (st_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Result-side back-pressure: random stall bursts, updated on the falling edge
  // so the block sees a stable ready at the rising edge.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      st_if.ready   <= 1'b0;
    end else if (allow_idle && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(0, 5);
      st_if.ready   <= 1'b0;
    end else begin
      st_if.ready   <= 1'b1;
    end
  end

  // One key-sample request. Entered and left at a falling edge. A gap lowers
  // valid for a whole burst, so valid never drops and rises in one step.
  task automatic send_key(input logic down);
    if (allow_idle && $urandom_range(0, 4) == 0) begin
      key_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    key_if.valid    <= 1'b1;
    key_if.key_down <= down;
    @(posedge clk);
    while (!key_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic key_run(input logic down, input int n);
    repeat (n) send_key(down);
  endtask

  // Wait until every accepted sample has produced its result, plus a margin.
  task automatic wait_quiet();
    key_if.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [CFG_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    // upper data bits are don't-care for an 8-bit register; keep them noisy
    pwdata  <= {24'($urandom), val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_thresholds(input int p, input int r, input int l, input int rpt);
    wait_quiet();
    cfg_write(REG_PRESS_DEB, p[CFG_W-1:0]);
    cfg_write(REG_RELEASE_DEB, r[CFG_W-1:0]);
    cfg_write(REG_LONG_PRESS, l[CFG_W-1:0]);
    cfg_write(REG_REPEAT, rpt[CFG_W-1:0]);
    @(negedge clk);
    pd_thr = p;
    rd_thr = r;
    lp_thr = l;
    rp_thr = rpt;
  endtask

  // Mostly short thresholds so presses get through long and repeat quickly;
  // now and then a large one.
  function automatic int pick_thr();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
  endfunction

  // Mostly well-formed presses: optional bounce before the press, a hold long
  // enough to reach short/long/repeat with short up-glitches inside, an
  // optional down-glitch in the release run, then a confirmed release.
  // The rest is plain noise.
  task automatic press_mix(input int budget);
    int sent;
    int hold;
    int pd_eff;
    int rd_eff;
    sent = 0;
    pd_eff = (pd_thr < 1) ? 1 : pd_thr;
    rd_eff = (rd_thr < 1) ? 1 : rd_thr;
    while (sent < budget) begin
      if ($urandom_range(0, 9) < 7) begin
        if (pd_thr > 1 && $urandom_range(0, 2) == 0) begin
          key_run(1'b1, $urandom_range(1, pd_thr - 1));
          key_run(1'b0, 1);
        end
        hold = pd_eff + $urandom_range(0, lp_thr + 3 * rp_thr + 2);
        for (int k = 0; k < hold; k++) begin
          if (rd_thr > 1 && $urandom_range(0, 15) == 0)
            key_run(1'b0, $urandom_range(1, rd_thr - 1));
          send_key(1'b1);
        end
        if (rd_thr > 1 && $urandom_range(0, 3) == 0) begin
          key_run(1'b0, $urandom_range(1, rd_thr - 1));
          key_run(1'b1, 1);
        end
        key_run(1'b0, rd_eff + $urandom_range(0, 3));
        sent += hold + rd_eff;
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_key(1'($urandom_range(0, 1)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    key_if.valid    = 1'b0;
    key_if.key_down = 1'b0;
    st_if.ready     = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    stall_left      = 0;
    allow_idle      = 1'b1;
    pd_thr          = PRESS_DEB_RST;
    rd_thr          = RELEASE_DEB_RST;
    lp_thr          = LONG_PRESS_RST;
    rp_thr          = REPEAT_RST;
    rst_n           = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed, reset thresholds (press 2, release 2): a lone down sample that
    // does not confirm, a confirmed press, the short-phase idle report, an
    // up-glitch cleared by a down sample while held, release from short,
    // the one-tick release phase and an idle tick that keeps the pair.
    key_run(1'b1, 1);
    key_run(1'b0, 1);
    key_run(1'b1, 3);
    key_run(1'b0, 1);
    key_run(1'b1, 1);
    key_run(1'b0, 4);

    // Directed, all thresholds at 1: short, long, repeat twice, release from
    // repeat; then short, long and release from long.
    set_thresholds(1, 1, 1, 1);
    key_run(1'b1, 4);
    key_run(1'b0, 2);
    key_run(1'b1, 2);
    key_run(1'b0, 2);

    // Random phases. Phase 0 runs the press threshold at its top value, the
    // others at 1, with one press held through long and two repeats; phase 1
    // writes every threshold as zero, and the last phase runs without any
    // gaps or stalls.
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 0)
        set_thresholds(255, 1, 1, 1);
      else if (ph == 1)
        set_thresholds(0, 0, 0, 0);
      else
        set_thresholds(pick_thr(), pick_thr(), pick_thr(), pick_thr());
      allow_idle = (ph != 8) && ($urandom_range(0, 3) != 0);
      if (ph == 0) begin
        key_run(1'b1, 255 + 3);
        key_run(1'b0, 2);
      end else begin
        press_mix(30);
      end
    end

    wait_quiet();
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: key_press_classifier.f
rtl/core/kpc_pkg.sv
rtl/core/kpc_key_if.sv
rtl/core/kpc_state_if.sv
rtl/core/kpc_cfg_regs.sv
rtl/core/kpc_fsm.sv
rtl/core/key_press_classifier.sv
tb/kpc_state_checker.sv
tb/key_press_classifier_tb.sv
